[src/pu_pkg.sv]
// ----------------------------------------------------------------------------
// Partition unrank package
// Widths, sequencer step codes, control word layout and the control program
// for the lexicographic integer partition unranking core.
// ----------------------------------------------------------------------------
package pu_pkg;

    localparam int TOTAL_W   = 7;
    localparam int RANK_W    = 21;
    localparam int PART_W    = 7;
    localparam int COUNT_W   = 21;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    // Sequencer steps; the step counter indexes the control program.
    typedef enum logic [2:0] {
        ST_BINIT,
        ST_BREAD,
        ST_BACC,
        ST_IDLE,
        ST_RDTOT,
        ST_CHECK,
        ST_WREAD,
        ST_WDEC
    } t_step;

    // Table read address source.
    typedef enum logic [1:0] {
        RS_NONE,
        RS_WALK,
        RS_TOTAL
    } t_rsel;

    // Datapath operation.
    typedef enum logic [2:0] {
        DOP_NONE,
        DOP_BINIT,
        DOP_BUILD,
        DOP_LOAD,
        DOP_CHECK,
        DOP_TAIL,
        DOP_WALK
    } t_dop;

    // Jump condition.
    typedef enum logic [2:0] {
        CD_ALWAYS,
        CD_BUILT,
        CD_ACCEPT,
        CD_ERR,
        CD_SHORT
    } t_cond;

    typedef struct packed {
        t_rsel rsel;
        t_dop  dop;
        t_cond cond;
        t_step jmp;
        t_step nxt;
    } t_uword;

    // Control program: one word per step. The jump target is taken when the
    // condition holds, the next target otherwise.
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{rsel: RS_NONE, dop: DOP_NONE, cond: CD_ALWAYS, jmp: ST_IDLE, nxt: ST_IDLE};
        unique case (step)
            ST_BINIT: w = '{rsel: RS_NONE,  dop: DOP_BINIT, cond: CD_ALWAYS,
                            jmp: ST_BREAD,  nxt: ST_BREAD};
            ST_BREAD: w = '{rsel: RS_WALK,  dop: DOP_NONE,  cond: CD_ALWAYS,
                            jmp: ST_BACC,   nxt: ST_BACC};
            ST_BACC:  w = '{rsel: RS_NONE,  dop: DOP_BUILD, cond: CD_BUILT,
                            jmp: ST_IDLE,   nxt: ST_BREAD};
            ST_IDLE:  w = '{rsel: RS_NONE,  dop: DOP_LOAD,  cond: CD_ACCEPT,
                            jmp: ST_RDTOT,  nxt: ST_IDLE};
            ST_RDTOT: w = '{rsel: RS_TOTAL, dop: DOP_NONE,  cond: CD_ALWAYS,
                            jmp: ST_CHECK,  nxt: ST_CHECK};
            ST_CHECK: w = '{rsel: RS_NONE,  dop: DOP_CHECK, cond: CD_ERR,
                            jmp: ST_IDLE,   nxt: ST_WREAD};
            ST_WREAD: w = '{rsel: RS_WALK,  dop: DOP_TAIL,  cond: CD_SHORT,
                            jmp: ST_IDLE,   nxt: ST_WDEC};
            ST_WDEC:  w = '{rsel: RS_NONE,  dop: DOP_WALK,  cond: CD_ALWAYS,
                            jmp: ST_WREAD,  nxt: ST_WREAD};
            default:  w = '{rsel: RS_NONE,  dop: DOP_NONE,  cond: CD_ALWAYS,
                            jmp: ST_IDLE,   nxt: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

[src/partition_unrank_core.sv]
// ----------------------------------------------------------------------------
// Partition unrank core
// Emits the k-th partition of n in lexicographic order, one part per item,
// driven by a small microcoded sequencer over two counting tables.
// ----------------------------------------------------------------------------
// After reset the core builds its counting tables, each table entry taking a
// table read step and an accumulate step, and accepts no item during that
// pass. A request then goes through acceptance, the p(n) read and the range
// check, then through walk steps, each a table read and a decision, where a
// step either emits one part or skips one candidate minimum part; the last
// part is emitted from the table read step. A walk for a total n has at most
// n - 1 steps, and a rejected request ends after the range check. Each walk
// step reads both tables at once and the registered read data feeds one
// subtract and compare. When a new part is due while the previous one waits
// unaccepted on the output, the sequencer holds.
// Parts come out nondecreasing with tlast on the final one; a total of zero,
// a total above MAX_N or a rank not below p(n) gives a single item with part
// zero, tlast and the error flag set.
module partition_unrank_core #(
    parameter int MAX_N = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [6:0] total, [27:7] rank, [31:28] zero
    input  logic [pu_pkg::S_TDATA_W-1:0]  i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [6:0] part, [7] zero
    output logic [pu_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                          o_m_tlast,
    // [0] error
    output logic                          o_m_tuser
);

    localparam int TabN = MAX_N + 1;
    localparam int NB   = $clog2(TabN);
    localparam int SAW  = $clog2(TabN * TabN);
    localparam int CW   = pu_pkg::COUNT_W;
    localparam logic [SAW-1:0] TAB_N_A = SAW'(TabN);

    // Counting tables: p(m), and partitions of m with smallest part <= j.
    logic [CW-1:0] r_total_count_table     [TabN];
    logic [CW-1:0] r_small_part_count_table[TabN * TabN];

    pu_pkg::t_step  r_step, n_step;
    pu_pkg::t_uword uw;

    logic [NB-1:0]             r_m, n_m;
    logic [NB-1:0]             r_j, n_j;
    logic [CW-1:0]             r_acc, n_acc;
    logic [pu_pkg::RANK_W-1:0] r_rank, n_rank;
    logic                      r_bad, n_bad;
    logic [CW-1:0]             r_tot_rd, r_spc_rd;

    logic                      r_ovalid;
    logic [pu_pkg::PART_W-1:0] r_opart;
    logic                      r_olast, r_oerr;

    logic [pu_pkg::TOTAL_W-1:0] in_total;
    logic [pu_pkg::RANK_W-1:0]  in_rank;
    logic                       accept;

    logic [NB-1:0]  diff;
    logic [SAW-1:0] row;
    logic [NB-1:0]  tot_raddr;
    logic [SAW-1:0] spc_raddr, spc_waddr;
    logic           tot_rd_en, spc_rd_en, spc_we, tot_we;
    logic [CW-1:0]  spc_rd_z, exact, acc_sum, starting;
    logic           f_eq, f_short, f_err, f_ge, f_built;
    logic           emit, hold, take;
    logic [pu_pkg::PART_W-1:0] em_part;
    logic           em_last, em_err;

    assign in_total   = i_s_tdata[pu_pkg::TOTAL_W-1:0];
    assign in_rank    = i_s_tdata[pu_pkg::TOTAL_W +: pu_pkg::RANK_W];
    assign o_s_tready = (r_step == pu_pkg::ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign uw         = pu_pkg::ucode(r_step);

    // Flags shared by the build pass and the walk.
    assign diff     = r_m - r_j;
    assign row      = SAW'(r_j - NB'(1));
    assign f_eq     = (r_j == r_m);
    assign f_short  = ({r_j, 1'b0} > {1'b0, r_m});
    assign f_err    = r_bad || (r_rank >= r_tot_rd);
    assign f_built  = f_eq && (r_m == NB'(MAX_N));
    // Row zero of the small-part table is never written and counts as zero.
    assign spc_rd_z = (r_j == NB'(1)) ? '0 : r_spc_rd;
    assign starting = r_tot_rd - spc_rd_z;
    assign f_ge     = (r_rank >= starting);
    assign exact    = f_eq ? CW'(1) : (f_short ? '0 : starting);
    assign acc_sum  = r_acc + exact;
    assign hold     = emit && r_ovalid && !i_m_tready;

    // Next step.
    always_comb begin
        take = 1'b0;
        unique case (uw.cond)
            pu_pkg::CD_ALWAYS: take = 1'b1;
            pu_pkg::CD_BUILT:  take = f_built;
            pu_pkg::CD_ACCEPT: take = accept;
            pu_pkg::CD_ERR:    take = f_err;
            pu_pkg::CD_SHORT:  take = f_short;
            default:           take = 1'b0;
        endcase
        n_step = r_step;
        if (!hold) begin
            n_step = take ? uw.jmp : uw.nxt;
        end
    end

    // Control word decode into datapath controls.
    always_comb begin
        tot_rd_en = 1'b0;
        spc_rd_en = 1'b0;
        tot_raddr = diff;
        spc_raddr = row * TAB_N_A + SAW'(diff);
        spc_waddr = SAW'(r_j) * TAB_N_A + SAW'(r_m);
        spc_we    = 1'b0;
        tot_we    = 1'b0;
        emit      = 1'b0;
        em_part   = '0;
        em_last   = 1'b0;
        em_err    = 1'b0;
        unique case (uw.rsel)
            pu_pkg::RS_WALK: begin
                tot_rd_en = !(uw.dop == pu_pkg::DOP_TAIL && f_short);
                spc_rd_en = tot_rd_en;
            end
            pu_pkg::RS_TOTAL: begin
                tot_rd_en = !r_bad;
                tot_raddr = r_m;
            end
            default: begin
                tot_rd_en = 1'b0;
            end
        endcase
        unique case (uw.dop)
            pu_pkg::DOP_BUILD: begin
                spc_we = 1'b1;
                tot_we = f_eq;
            end
            pu_pkg::DOP_CHECK: begin
                emit    = f_err;
                em_last = 1'b1;
                em_err  = 1'b1;
            end
            pu_pkg::DOP_TAIL: begin
                emit    = f_short;
                em_part = pu_pkg::PART_W'(r_m);
                em_last = 1'b1;
            end
            pu_pkg::DOP_WALK: begin
                emit    = !f_ge;
                em_part = pu_pkg::PART_W'(r_j);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_m    = r_m;
        n_j    = r_j;
        n_acc  = r_acc;
        n_rank = r_rank;
        n_bad  = r_bad;
        case (uw.dop)
            pu_pkg::DOP_BINIT: begin
                n_m   = NB'(1);
                n_j   = NB'(1);
                n_acc = '0;
            end
            pu_pkg::DOP_BUILD: begin
                n_acc = f_eq ? '0 : acc_sum;
                n_j   = f_eq ? NB'(1) : r_j + NB'(1);
                n_m   = f_eq ? r_m + NB'(1) : r_m;
            end
            pu_pkg::DOP_LOAD: begin
                if (accept) begin
                    n_m    = in_total[NB-1:0];
                    n_j    = NB'(1);
                    n_rank = in_rank;
                    n_bad  = (in_total == '0) || (in_total > pu_pkg::TOTAL_W'(MAX_N));
                end
            end
            pu_pkg::DOP_WALK: begin
                if (f_ge) begin
                    n_rank = r_rank - starting;
                    n_j    = r_j + NB'(1);
                end else if (!hold) begin
                    n_m = r_m - r_j;
                end
            end
            default: begin
                n_m = r_m;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= pu_pkg::ST_BINIT;
            r_ovalid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (emit && !hold) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold) begin
            r_m    <= n_m;
            r_j    <= n_j;
            r_acc  <= n_acc;
            r_rank <= n_rank;
            r_bad  <= n_bad;
        end
        if (emit && !hold) begin
            r_opart <= em_part;
            r_olast <= em_last;
            r_oerr  <= em_err;
        end
    end

    // Table memories.
    always_ff @(posedge i_clk) begin
        if (tot_rd_en) begin
            r_tot_rd <= r_total_count_table[tot_raddr];
        end
        if (spc_rd_en) begin
            r_spc_rd <= r_small_part_count_table[spc_raddr];
        end
        if (spc_we) begin
            r_small_part_count_table[spc_waddr] <= acc_sum;
        end
        if (tot_we) begin
            r_total_count_table[r_m] <= acc_sum;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(pu_pkg::M_TDATA_W - pu_pkg::PART_W){1'b0}}, r_opart};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_oerr;

    // A walk decision is only reached when the current minimum still fits twice.
    a_walk_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == pu_pkg::ST_WDEC) |-> !f_short)
        else $error("walk decision with minimum part above half the sum");

    // A rejected request leaves exactly one flagged final item.
    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == pu_pkg::ST_CHECK && f_err && !hold)
            |=> (o_m_tvalid && o_m_tlast && o_m_tuser && o_m_tdata == '0))
        else $error("error result not presented as a single flagged item");

    // Parts emitted by a walk step are nonzero and never final.
    a_walk_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == pu_pkg::ST_WDEC && emit && !hold)
            |=> (o_m_tvalid && o_m_tdata != '0 && !o_m_tlast && !o_m_tuser))
        else $error("bad intermediate part");

endmodule
